### hdl/qah_pkg.sv
package qah_pkg;

	// Input coordinate format.
	localparam int CoordW = 32;
	localparam int FracW = 16;

	// Edge length datapath.
	localparam int DiffW = CoordW + 1;
	localparam int SqW = 2 * DiffW;
	localparam int NormW = SqW + 2;
	localparam int LenW = NormW / 2;
	localparam int NumEdge = 5;

	// Heron datapath: factor magnitudes are split into two halves for the multipliers.
	localparam int FacW = LenW + 2;
	localparam int HalfW = (FacW + 1) / 2;
	localparam int PairW = 4 * HalfW;
	localparam int ProdW = 8 * HalfW;
	localparam int AreaShift = 2 * FracW + 4;
	localparam int AreaBits = 49;
	localparam int AreaRadW = 2 * AreaBits;
	localparam int AreaW = 48;

	// Pipeline depth: diff, square, sum, length root, factors, four product stages,
	// radicand, area root, output.
	localparam int NumStg = 3 + LenW + 6 + AreaBits + 1;

	typedef struct packed {
		logic signed [CoordW-1:0] p0_x;
		logic signed [CoordW-1:0] p0_y;
		logic signed [CoordW-1:0] p0_z;
		logic signed [CoordW-1:0] p1_x;
		logic signed [CoordW-1:0] p1_y;
		logic signed [CoordW-1:0] p1_z;
		logic signed [CoordW-1:0] p2_x;
		logic signed [CoordW-1:0] p2_y;
		logic signed [CoordW-1:0] p2_z;
		logic signed [CoordW-1:0] p3_x;
		logic signed [CoordW-1:0] p3_y;
		logic signed [CoordW-1:0] p3_z;
	} qah_in_t;

	typedef struct packed {
		logic [AreaW-1:0] area;
		logic radicand_clamped;
	} qah_out_t;

endpackage

### hdl/qah_if.sv
interface qah_in_if;
	import qah_pkg::*;
	logic valid;
	logic ready;
	qah_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface qah_out_if;
	import qah_pkg::*;
	logic valid;
	logic ready;
	qah_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/quad_area_heron_top.sv
// Channel | Direction | Beat contents
// quad    | in        | four vertices p0..p3, x/y/z each signed Q16.16
// res     | out       | area (unsigned Q32.16, saturated), radicand_clamped
//
// One beat is accepted per cycle while a stall on res does not hold the pipe.
// The depth comes from the two bit-serial square root chains (34 and 49 steps).
// All stages advance together whenever the output register is empty or drained.
// A stall on res freezes the whole pipe, so nothing is lost or repeated.
// Reset clears only the valid bits.
module quad_area_heron_top
	import qah_pkg::*;
(
	input logic clk,
	input logic arst_n,
	qah_in_if.sink quad,
	qah_out_if.source res
);

	localparam int EdgeP [NumEdge] = '{0, 1, 2, 3, 0};
	localparam int EdgeQ [NumEdge] = '{1, 2, 3, 0, 2};
	localparam int TriX [2] = '{0, 2};
	localparam int TriY [2] = '{1, 3};
	localparam int TriZ = 4;

	logic [NumStg-1:0] vld_q;
	logic adv;
	logic signed [CoordW-1:0] vtx [4][3];

	// Pipeline advance and handshake.
	assign adv = !vld_q[NumStg-1] || res.ready;
	assign quad.ready = adv;
	assign res.valid = vld_q[NumStg-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NumStg-2:0], quad.valid};
		end
	end

	// Vertex table from the input beat.
	always_comb begin
		vtx[0][0] = quad.data.p0_x; vtx[0][1] = quad.data.p0_y; vtx[0][2] = quad.data.p0_z;
		vtx[1][0] = quad.data.p1_x; vtx[1][1] = quad.data.p1_y; vtx[1][2] = quad.data.p1_z;
		vtx[2][0] = quad.data.p2_x; vtx[2][1] = quad.data.p2_y; vtx[2][2] = quad.data.p2_z;
		vtx[3][0] = quad.data.p3_x; vtx[3][1] = quad.data.p3_y; vtx[3][2] = quad.data.p3_z;
	end

	logic [DiffW-1:0] mag_s1 [NumEdge][3];
	logic [SqW-1:0] sq_s2 [NumEdge][3];
	logic [NormW-1:0] nrm_s3 [NumEdge];

	// Stages 1 to 3: absolute differences, squares, squared norms.
	for (genvar e = 0; e < NumEdge; e++) begin : g_edge
		for (genvar k = 0; k < 3; k++) begin : g_comp
			logic signed [DiffW-1:0] diff;
			assign diff = $signed({vtx[EdgeQ[e]][k][CoordW-1], vtx[EdgeQ[e]][k]})
				- $signed({vtx[EdgeP[e]][k][CoordW-1], vtx[EdgeP[e]][k]});
			always_ff @(posedge clk) begin
				if (adv) begin
					mag_s1[e][k] <= diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
					sq_s2[e][k] <= SqW'(mag_s1[e][k] * mag_s1[e][k]);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				nrm_s3[e] <= NormW'(sq_s2[e][0]) + NormW'(sq_s2[e][1]) + NormW'(sq_s2[e][2]);
			end
		end
	end

	// Length square roots, one result bit per stage.
	logic [LenW-1:0] lroot_w [0:LenW][NumEdge];
	logic [NormW-1:0] lrem_w [0:LenW][NumEdge];

	for (genvar e = 0; e < NumEdge; e++) begin : g_lin
		assign lroot_w[0][e] = '0;
		assign lrem_w[0][e] = nrm_s3[e];
	end

	for (genvar j = 0; j < LenW; j++) begin : g_lsq
		for (genvar e = 0; e < NumEdge; e++) begin : g_le
			localparam int Bit = LenW - 1 - j;
			logic [NormW:0] trial;
			logic [LenW-1:0] root_q;
			logic [NormW-1:0] rem_q;
			assign trial = ((NormW + 1)'(lroot_w[j][e]) << (Bit + 1))
				+ ((NormW + 1)'(1) << (2 * Bit));
			always_ff @(posedge clk) begin
				if (adv) begin
					if ({1'b0, lrem_w[j][e]} >= trial) begin
						rem_q <= lrem_w[j][e] - trial[NormW-1:0];
						root_q <= lroot_w[j][e] | (LenW'(1) << Bit);
					end else begin
						rem_q <= lrem_w[j][e];
						root_q <= lroot_w[j][e];
					end
				end
			end
			assign lroot_w[j+1][e] = root_q;
			assign lrem_w[j+1][e] = rem_q;
		end
	end

	// Heron stages for both triangles.
	logic [FacW-1:0] fac_s38 [2][4];
	logic cl_s38 [2];
	logic [2*HalfW-1:0] pa_s39 [2][2][4];
	logic cl_s39 [2];
	logic [PairW-1:0] pb_s40 [2][2];
	logic cl_s40 [2];
	logic [2*HalfW-1:0] qa_s41 [2][4][4];
	logic cl_s41 [2];
	logic [ProdW-1:0] qb_s42 [2][4];
	logic cl_s42 [2];
	logic [AreaRadW-1:0] rad_s43 [2];
	logic sat_s43 [2];
	logic cl_s43;

	for (genvar t = 0; t < 2; t++) begin : g_tri
		logic signed [FacW:0] fs [4];
		logic [3:0] neg;
		logic any_zero;
		logic [ProdW-1:0] prod;

		// Factors of sixteen times the squared area.
		always_comb begin
			fs[0] = $signed({3'b0, lroot_w[LenW][TriX[t]]}) + $signed({3'b0, lroot_w[LenW][TriY[t]]})
				+ $signed({3'b0, lroot_w[LenW][TriZ]});
			fs[1] = $signed({3'b0, lroot_w[LenW][TriY[t]]}) + $signed({3'b0, lroot_w[LenW][TriZ]})
				- $signed({3'b0, lroot_w[LenW][TriX[t]]});
			fs[2] = $signed({3'b0, lroot_w[LenW][TriX[t]]}) + $signed({3'b0, lroot_w[LenW][TriZ]})
				- $signed({3'b0, lroot_w[LenW][TriY[t]]});
			fs[3] = $signed({3'b0, lroot_w[LenW][TriX[t]]}) + $signed({3'b0, lroot_w[LenW][TriY[t]]})
				- $signed({3'b0, lroot_w[LenW][TriZ]});
			any_zero = 1'b0;
			for (int i = 0; i < 4; i++) begin
				neg[i] = fs[i][FacW];
				if (fs[i] == '0) begin
					any_zero = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int i = 0; i < 4; i++) begin
					fac_s38[t][i] <= neg[i] ? FacW'(-fs[i]) : FacW'(fs[i]);
				end
				cl_s38[t] <= (^neg) && !any_zero;
			end
		end

		// First products: halves of each factor pair.
		for (genvar u = 0; u < 2; u++) begin : g_pair
			logic [2*HalfW-1:0] ma;
			logic [2*HalfW-1:0] mb;
			assign ma = (2 * HalfW)'(fac_s38[t][2*u]);
			assign mb = (2 * HalfW)'(fac_s38[t][2*u+1]);
			always_ff @(posedge clk) begin
				if (adv) begin
					pa_s39[t][u][0] <= ma[HalfW-1:0] * mb[HalfW-1:0];
					pa_s39[t][u][1] <= ma[HalfW-1:0] * mb[2*HalfW-1:HalfW];
					pa_s39[t][u][2] <= ma[2*HalfW-1:HalfW] * mb[HalfW-1:0];
					pa_s39[t][u][3] <= ma[2*HalfW-1:HalfW] * mb[2*HalfW-1:HalfW];
					pb_s40[t][u] <= (PairW'(pa_s39[t][u][3]) << (2 * HalfW))
						+ ((PairW'(pa_s39[t][u][1]) + PairW'(pa_s39[t][u][2])) << HalfW)
						+ PairW'(pa_s39[t][u][0]);
				end
			end
		end

		// Second product: limb partials, row sums, final sum.
		always_comb begin
			prod = '0;
			for (int i = 0; i < 4; i++) begin
				prod = prod + (qb_s42[t][i] << (HalfW * i));
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cl_s39[t] <= cl_s38[t];
				cl_s40[t] <= cl_s39[t];
				cl_s41[t] <= cl_s40[t];
				cl_s42[t] <= cl_s41[t];
				for (int i = 0; i < 4; i++) begin
					for (int j = 0; j < 4; j++) begin
						qa_s41[t][i][j] <= pb_s40[t][0][HalfW*i +: HalfW]
							* pb_s40[t][1][HalfW*j +: HalfW];
					end
					qb_s42[t][i] <= ProdW'(qa_s41[t][i][0])
						+ (ProdW'(qa_s41[t][i][1]) << HalfW)
						+ (ProdW'(qa_s41[t][i][2]) << (2 * HalfW))
						+ (ProdW'(qa_s41[t][i][3]) << (3 * HalfW));
				end
				// A clamped triangle contributes zero area.
				rad_s43[t] <= cl_s42[t] ? '0 : AreaRadW'(prod >> AreaShift);
				sat_s43[t] <= !cl_s42[t] && ((prod >> (AreaShift + AreaRadW)) != '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cl_s43 <= cl_s42[0] || cl_s42[1];
		end
	end

	// Area square roots, one result bit per stage.
	logic [AreaBits-1:0] aroot_w [0:AreaBits][2];
	logic [AreaRadW-1:0] arem_w [0:AreaBits][2];
	logic asat_w [0:AreaBits][2];
	logic aflg_w [0:AreaBits];

	for (genvar t = 0; t < 2; t++) begin : g_ain
		assign aroot_w[0][t] = '0;
		assign arem_w[0][t] = rad_s43[t];
		assign asat_w[0][t] = sat_s43[t];
	end
	assign aflg_w[0] = cl_s43;

	for (genvar j = 0; j < AreaBits; j++) begin : g_asq
		logic flg_q;
		always_ff @(posedge clk) begin
			if (adv) begin
				flg_q <= aflg_w[j];
			end
		end
		assign aflg_w[j+1] = flg_q;
		for (genvar t = 0; t < 2; t++) begin : g_at
			localparam int Bit = AreaBits - 1 - j;
			logic [AreaRadW:0] trial;
			logic [AreaBits-1:0] root_q;
			logic [AreaRadW-1:0] rem_q;
			logic sat_q;
			assign trial = ((AreaRadW + 1)'(aroot_w[j][t]) << (Bit + 1))
				+ ((AreaRadW + 1)'(1) << (2 * Bit));
			always_ff @(posedge clk) begin
				if (adv) begin
					sat_q <= asat_w[j][t];
					if ({1'b0, arem_w[j][t]} >= trial) begin
						rem_q <= arem_w[j][t] - trial[AreaRadW-1:0];
						root_q <= aroot_w[j][t] | (AreaBits'(1) << Bit);
					end else begin
						rem_q <= arem_w[j][t];
						root_q <= aroot_w[j][t];
					end
				end
			end
			assign aroot_w[j+1][t] = root_q;
			assign arem_w[j+1][t] = rem_q;
			assign asat_w[j+1][t] = sat_q;
		end
	end

	// Output register: sum of the two areas, saturated.
	logic [AreaBits-1:0] tri_area [2];
	logic [AreaBits:0] area_sum;
	qah_out_t res_q;

	always_comb begin
		for (int t = 0; t < 2; t++) begin
			tri_area[t] = asat_w[AreaBits][t] ? '1 : aroot_w[AreaBits][t];
		end
		area_sum = (AreaBits + 1)'(tri_area[0]) + (AreaBits + 1)'(tri_area[1]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.area <= (area_sum[AreaBits:AreaW] != '0) ? '1 : area_sum[AreaW-1:0];
			res_q.radicand_clamped <= aflg_w[AreaBits];
		end
	end

	assign res.data = res_q;

endmodule
